@@ hdl/range_bearing_zone_classifier_macros.svh @@
// Assertion helpers shared by the zone classifier RTL.
// Both macros expect clk and arst_n in scope.
`ifndef RANGE_BEARING_ZONE_CLASSIFIER_MACROS_SVH
`define RANGE_BEARING_ZONE_CLASSIFIER_MACROS_SVH
`ifndef ASSERT_OFF
`define RBZC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rbzc: same-cycle check failed");
`define RBZC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rbzc: next-cycle check failed");
`else
`define RBZC_ASSERT_IMP(lbl, ante, cons)
`define RBZC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ hdl/rbzc_pkg.sv @@
package rbzc_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_SETPOINT     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_THRESHOLD = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SET_BEARING        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BEARING_THRESHOLD  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_ZONE_COUNT   = 3'd4;

	localparam logic [23:0] RST_RANGE_SETPOINT     = 24'd6144;
	localparam logic [23:0] RST_DISTANCE_THRESHOLD = 24'd2048;
	localparam logic [15:0] RST_SET_BEARING        = 16'd0;
	localparam logic [14:0] RST_BEARING_THRESHOLD  = 15'd5461;
	localparam logic [3:0]  RST_ANGLE_ZONE_COUNT   = 4'd3;

	// CORDIC datapath: positions are prescaled so the top lands near bit 57
	localparam int PRESHIFT_BASE = 57;
	localparam int CW            = 61;
	localparam int ZW            = 34;
	localparam int TABLE_LEN     = 24;

	// atan(2^-i) with 2^31 = pi
	localparam logic signed [ZW-1:0] ATAN_TAB [TABLE_LEN] = '{
		34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
		34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
		34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
		34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
		34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
		34'sd652,       34'sd326,       34'sd163,       34'sd81
	};
	localparam logic signed [ZW-1:0] Z_QUARTER = 34'sd1073741824;

	// zone codes
	localparam logic [1:0] ZONE_BELOW  = 2'd0;
	localparam logic [1:0] ZONE_INSIDE = 2'd1;
	localparam logic [1:0] ZONE_ABOVE  = 2'd2;

	localparam logic [2:0] REWARD_BOTH = 3'b010;
	localparam logic [2:0] REWARD_ONE  = 3'b001;
	localparam logic [2:0] REWARD_NONE = 3'b111;

	// band limits, two's complement, formed without wrap
	typedef struct packed {
		logic [25:0] dlo;
		logic [25:0] dhi;
		logic [17:0] blo;
		logic [17:0] bhi;
		logic [3:0]  azc;
	} rbzc_limits_t;

endpackage

@@ hdl/rbzc_if.sv @@
interface rbzc_pose_if #(
	parameter int POSITION_BITS = 24,
	parameter int ANGLE_BITS = 16
);
	logic valid;
	logic ready;
	logic signed [POSITION_BITS-1:0] leader_x;
	logic signed [POSITION_BITS-1:0] leader_y;
	logic signed [ANGLE_BITS-1:0] leader_yaw;
	logic signed [POSITION_BITS-1:0] follower_x;
	logic signed [POSITION_BITS-1:0] follower_y;

	modport source (
		output valid, leader_x, leader_y, leader_yaw, follower_x, follower_y,
		input ready
	);
	modport sink (
		input valid, leader_x, leader_y, leader_yaw, follower_x, follower_y,
		output ready
	);
endinterface

interface rbzc_result_if #(
	parameter int POSITION_BITS = 24,
	parameter int ANGLE_BITS = 16
);
	logic valid;
	logic ready;
	logic [5:0] zone_index;
	logic signed [2:0] reward;
	logic [POSITION_BITS:0] range;
	logic signed [ANGLE_BITS-1:0] bearing;

	modport source (output valid, zone_index, reward, range, bearing, input ready);
	modport sink (input valid, zone_index, reward, range, bearing, output ready);
endinterface

interface rbzc_cfg_if;
	logic valid;
	logic ready;
	logic [2:0] index;
	logic [23:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/rbzc_range.sv @@
module rbzc_range #(
	parameter int POSITION_BITS = 24,
	parameter int LAT = 27
) (
	input  logic clk,
	input  logic en,
	input  logic signed [POSITION_BITS:0] dx,
	input  logic signed [POSITION_BITS:0] dy,
	output logic [POSITION_BITS:0] range_out
);
	localparam int DW   = POSITION_BITS + 1;
	localparam int SW   = 2 * DW;
	localparam int RW   = DW;
	localparam int REMW = RW + 2;
	localparam int NSQ  = RW;
	localparam int PAD  = LAT - 2 - NSQ;

	logic [DW-1:0] ax, ay;
	logic [SW-1:0] sqx, sqy;
	logic [SW-1:0] sqx_s2, sqy_s2;
	logic [SW-1:0] rad_s [NSQ];
	logic [REMW-1:0] rem_s [NSQ];
	logic [RW-1:0] root_s [NSQ+1];

	assign ax = dx[DW-1] ? -dx : dx;
	assign ay = dy[DW-1] ? -dy : dy;
	assign sqx = ax * ax;
	assign sqy = ay * ay;

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s2 <= sqx;
			sqy_s2 <= sqy;
			rad_s[0] <= sqx_s2 + sqy_s2;
		end
	end

	// restoring square root, one root bit per stage
	for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
		logic [REMW-1:0] rem_in;
		logic [RW-1:0] root_in;
		logic [REMW+1:0] cur, trial;
		logic take;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign root_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[k];
			assign root_in = root_s[k];
		end

		assign cur = {rem_in, rad_s[k][SW-1 -: 2]};
		assign trial = (REMW+2)'({root_in, 2'b01});
		assign take = (cur >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				root_s[k+1] <= {root_in[RW-2:0], take};
			end
		end

		if (k < NSQ - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1] <= take ? REMW'(cur - trial) : REMW'(cur);
					rad_s[k+1] <= rad_s[k] << 2;
				end
			end
		end
	end

	if (PAD == 0) begin : g_nopad
		assign range_out = root_s[NSQ];
	end else begin : g_pad
		logic [RW-1:0] pad_s [1:PAD];
		always_ff @(posedge clk) begin
			if (en) begin
				pad_s[1] <= root_s[NSQ];
				for (int j = 2; j <= PAD; j++) begin
					pad_s[j] <= pad_s[j-1];
				end
			end
		end
		assign range_out = pad_s[PAD];
	end

endmodule

@@ hdl/rbzc_cordic.sv @@
module rbzc_cordic #(
	parameter int POSITION_BITS = 24,
	parameter int ANGLE_BITS = 16,
	parameter int CORDIC_STAGES = 16,
	parameter int LAT = 27
) (
	input  logic clk,
	input  logic en,
	input  logic signed [POSITION_BITS:0] dx,
	input  logic signed [POSITION_BITS:0] dy,
	input  logic signed [ANGLE_BITS-1:0] yaw,
	output logic signed [ANGLE_BITS-1:0] bearing_out
);
	import rbzc_pkg::*;

	localparam int DW       = POSITION_BITS + 1;
	localparam int PRESHIFT = PRESHIFT_BASE - POSITION_BITS;
	localparam int NS       = CORDIC_STAGES;
	localparam int SH       = 32 - ANGLE_BITS;
	localparam int PAD      = LAT - NS - 2;
	localparam logic signed [ZW-1:0] Z_HALF = ZW'(1) << (SH - 1);

	logic signed [CW-1:0] xp, yp, x0, y0;
	logic signed [ZW-1:0] z0;
	logic signed [CW-1:0] x_s [NS];
	logic signed [CW-1:0] y_s [NS];
	logic signed [ZW-1:0] z_s [NS+1];
	logic zero_s [NS+1];
	logic [ANGLE_BITS-1:0] yaw_s [NS+1];
	logic signed [ZW-1:0] zr;
	logic [ANGLE_BITS-1:0] zb, braw;
	logic signed [ANGLE_BITS-1:0] bearing_r;

	assign xp = {{(CW-DW){dx[DW-1]}}, dx} << PRESHIFT;
	assign yp = {{(CW-DW){dy[DW-1]}}, dy} << PRESHIFT;

	// left half plane: turn by a quarter first
	always_comb begin
		x0 = xp;
		y0 = yp;
		z0 = '0;
		if (xp[CW-1]) begin
			if (!yp[CW-1]) begin
				x0 = yp;
				y0 = -xp;
				z0 = Z_QUARTER;
			end else begin
				x0 = -yp;
				y0 = xp;
				z0 = -Z_QUARTER;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= x0;
			y_s[0] <= y0;
			z_s[0] <= z0;
			zero_s[0] <= (dx == '0) && (dy == '0);
			yaw_s[0] <= yaw;
		end
	end

	for (genvar i = 0; i < NS; i++) begin : g_rot
		logic neg;
		assign neg = y_s[i][CW-1];

		always_ff @(posedge clk) begin
			if (en) begin
				z_s[i+1] <= neg ? z_s[i] - ATAN_TAB[i] : z_s[i] + ATAN_TAB[i];
				zero_s[i+1] <= zero_s[i];
				yaw_s[i+1] <= yaw_s[i];
			end
		end

		if (i < NS - 1) begin : g_xy
			logic signed [CW-1:0] xs, ys;
			assign xs = x_s[i] >>> i;
			assign ys = y_s[i] >>> i;
			always_ff @(posedge clk) begin
				if (en) begin
					x_s[i+1] <= neg ? x_s[i] - ys : x_s[i] + ys;
					y_s[i+1] <= neg ? y_s[i] + xs : y_s[i] - xs;
				end
			end
		end
	end

	// round to ANGLE_BITS, then yaw - atan2 + pi (pi flips the top bit)
	assign zr = (zero_s[NS] ? '0 : z_s[NS]) + Z_HALF;
	assign zb = zr[SH +: ANGLE_BITS];
	assign braw = yaw_s[NS] - zb;

	always_ff @(posedge clk) begin
		if (en) begin
			bearing_r <= {~braw[ANGLE_BITS-1], braw[ANGLE_BITS-2:0]};
		end
	end

	if (PAD == 0) begin : g_nopad
		assign bearing_out = bearing_r;
	end else begin : g_pad
		logic signed [ANGLE_BITS-1:0] pad_s [1:PAD];
		always_ff @(posedge clk) begin
			if (en) begin
				pad_s[1] <= bearing_r;
				for (int j = 2; j <= PAD; j++) begin
					pad_s[j] <= pad_s[j-1];
				end
			end
		end
		assign bearing_out = pad_s[PAD];
	end

endmodule

@@ hdl/rbzc_classify.sv @@
`include "range_bearing_zone_classifier_macros.svh"

module rbzc_classify #(
	parameter int POSITION_BITS = 24,
	parameter int ANGLE_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  logic in_valid,
	input  logic [POSITION_BITS:0] range_in,
	input  logic signed [ANGLE_BITS-1:0] bearing_in,
	input  rbzc_pkg::rbzc_limits_t lim,
	output logic out_valid,
	output logic [5:0] zone_index,
	output logic [2:0] reward,
	output logic [POSITION_BITS:0] range_out,
	output logic signed [ANGLE_BITS-1:0] bearing_out
);
	import rbzc_pkg::*;

	localparam int CRW = ((POSITION_BITS + 1 > 25) ? POSITION_BITS + 1 : 25) + 1;
	localparam int CBW = (ANGLE_BITS > 18) ? ANGLE_BITS : 18;

	logic signed [CRW-1:0] r_x, dlo_x, dhi_x;
	logic signed [CBW-1:0] b_x, blo_x, bhi_x;
	logic out_d, out_b;
	logic [1:0] zd, zbz, wsum;
	logic [5:0] zone;
	logic [2:0] rew;
	logic out_valid_q;

	assign r_x   = $signed(CRW'(range_in));
	assign dlo_x = CRW'($signed(lim.dlo));
	assign dhi_x = CRW'($signed(lim.dhi));
	assign b_x   = CBW'(bearing_in);
	assign blo_x = CBW'($signed(lim.blo));
	assign bhi_x = CBW'($signed(lim.bhi));

	// reward band is closed; zone band is open at both ends
	assign out_d = (r_x > dhi_x) || (r_x < dlo_x);
	assign out_b = (b_x > bhi_x) || (b_x < blo_x);
	assign zd  = (r_x <= dlo_x) ? ZONE_BELOW : ((r_x < dhi_x) ? ZONE_INSIDE : ZONE_ABOVE);
	assign zbz = (b_x <= blo_x) ? ZONE_BELOW : ((b_x < bhi_x) ? ZONE_INSIDE : ZONE_ABOVE);
	assign zone = 6'(({4'b0, zd} * {2'b0, lim.azc}) + {4'b0, zbz});
	assign wsum = {1'b0, out_d} + {1'b0, out_b};

	always_comb begin
		unique case (wsum)
			2'd0: rew = REWARD_BOTH;
			2'd1: rew = REWARD_ONE;
			default: rew = REWARD_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			zone_index <= zone;
			reward <= rew;
			range_out <= range_in;
			bearing_out <= bearing_in;
		end
	end

	assign out_valid = out_valid_q;

	`RBZC_ASSERT_IMP(a_reward_code, out_valid_q, reward == REWARD_BOTH || reward == REWARD_ONE || reward == REWARD_NONE)
	`RBZC_ASSERT_IMP(a_zone_bound, out_valid_q, zone_index <= 6'd32)

endmodule

@@ hdl/range_bearing_zone_classifier.sv @@
// Range, bearing and zone classifier for a leader/follower pose pair.
//
// pose   : request carries leader x/y/yaw and follower x/y (Q.12 m, binary angles).
// result : zone_index, reward, range and wrapped bearing, one per pose request.
// cfg    : register writes (index 0..4: range set point, range threshold,
//          bearing set point, bearing threshold, angle zone count); cfg.ready is
//          always high, unknown indexes are dropped. Write only while the block is empty.
//
// A pose is registered as dx/dy/yaw, runs through the range and CORDIC pipelines,
// both padded to equal depth, and lands in the classifier's output register.
// The square root (one root bit per stage) sets the depth at the default sizes.
// Throughput: one request per cycle, unless result stalls while the pipeline is full.
// Reset clears all valid bits and loads the register reset values.
// When result is stalled the pipeline still advances into empty slots; it
// holds only once the last internal stage and the output register are both full.
`include "range_bearing_zone_classifier_macros.svh"

module range_bearing_zone_classifier #(
	parameter int POSITION_BITS = 24,
	parameter int ANGLE_BITS = 16,
	parameter int CORDIC_STAGES = 16
) (
	input logic clk,
	input logic arst_n,
	rbzc_pose_if.sink pose,
	rbzc_result_if.source result,
	rbzc_cfg_if.sink cfg
);
	import rbzc_pkg::*;

	localparam int DW         = POSITION_BITS + 1;
	localparam int RANGE_LAT  = POSITION_BITS + 3;
	localparam int CORDIC_LAT = CORDIC_STAGES + 2;
	localparam int LAT        = (RANGE_LAT > CORDIC_LAT) ? RANGE_LAT : CORDIC_LAT;

	logic [23:0] range_setpoint_q, distance_threshold_q;
	logic [15:0] set_bearing_q;
	logic [14:0] bearing_threshold_q;
	logic [3:0] angle_zone_count_q;
	rbzc_limits_t limits_q;

	logic adv, out_load, out_valid;
	logic [LAT+1:1] vld_s;
	logic signed [DW-1:0] dx_s1, dy_s1;
	logic signed [ANGLE_BITS-1:0] yaw_s1;
	logic [DW-1:0] range_pipe;
	logic signed [ANGLE_BITS-1:0] bearing_pipe;

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_setpoint_q <= RST_RANGE_SETPOINT;
			distance_threshold_q <= RST_DISTANCE_THRESHOLD;
			set_bearing_q <= RST_SET_BEARING;
			bearing_threshold_q <= RST_BEARING_THRESHOLD;
			angle_zone_count_q <= RST_ANGLE_ZONE_COUNT;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_RANGE_SETPOINT: range_setpoint_q <= cfg.data;
				CFG_DISTANCE_THRESHOLD: distance_threshold_q <= cfg.data;
				CFG_SET_BEARING: set_bearing_q <= cfg.data[15:0];
				CFG_BEARING_THRESHOLD: bearing_threshold_q <= cfg.data[14:0];
				CFG_ANGLE_ZONE_COUNT: angle_zone_count_q <= cfg.data[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		limits_q.dlo <= {2'b0, range_setpoint_q} - {2'b0, distance_threshold_q};
		limits_q.dhi <= {2'b0, range_setpoint_q} + {2'b0, distance_threshold_q};
		limits_q.blo <= {{2{set_bearing_q[15]}}, set_bearing_q} - {3'b0, bearing_threshold_q};
		limits_q.bhi <= {{2{set_bearing_q[15]}}, set_bearing_q} + {3'b0, bearing_threshold_q};
		limits_q.azc <= angle_zone_count_q;
	end

	// flow control: advance unless the last stage is full and cannot unload
	assign out_load = !out_valid || result.ready;
	assign adv = !vld_s[LAT+1] || out_load;
	assign pose.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[LAT:1], pose.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1 <= {pose.follower_x[POSITION_BITS-1], pose.follower_x}
				- {pose.leader_x[POSITION_BITS-1], pose.leader_x};
			dy_s1 <= {pose.follower_y[POSITION_BITS-1], pose.follower_y}
				- {pose.leader_y[POSITION_BITS-1], pose.leader_y};
			yaw_s1 <= pose.leader_yaw;
		end
	end

	rbzc_range #(
		.POSITION_BITS(POSITION_BITS),
		.LAT(LAT)
	) u_range (
		.clk(clk),
		.en(adv),
		.dx(dx_s1),
		.dy(dy_s1),
		.range_out(range_pipe)
	);

	rbzc_cordic #(
		.POSITION_BITS(POSITION_BITS),
		.ANGLE_BITS(ANGLE_BITS),
		.CORDIC_STAGES(CORDIC_STAGES),
		.LAT(LAT)
	) u_cordic (
		.clk(clk),
		.en(adv),
		.dx(dx_s1),
		.dy(dy_s1),
		.yaw(yaw_s1),
		.bearing_out(bearing_pipe)
	);

	rbzc_classify #(
		.POSITION_BITS(POSITION_BITS),
		.ANGLE_BITS(ANGLE_BITS)
	) u_classify (
		.clk(clk),
		.arst_n(arst_n),
		.load(out_load),
		.in_valid(vld_s[LAT+1]),
		.range_in(range_pipe),
		.bearing_in(bearing_pipe),
		.lim(limits_q),
		.out_valid(out_valid),
		.zone_index(result.zone_index),
		.reward(result.reward),
		.range_out(result.range),
		.bearing_out(result.bearing)
	);

	assign result.valid = out_valid;

	`RBZC_ASSERT_NXT(a_tail_holds, vld_s[LAT+1] && !adv, vld_s[LAT+1])
	`RBZC_ASSERT_NXT(a_accept_enters, pose.valid && adv, vld_s[1])

endmodule
